// ===== rtl/core/touch_button_qualifier_top_macros.svh =====
// ----------------------------------------------------------------------------
// touch button qualifier assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef TOUCH_BUTTON_QUALIFIER_TOP_MACROS_SVH
`define TOUCH_BUTTON_QUALIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TBQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbq assertion failed");

// next-cycle implication
`define TBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbq assertion failed");

`else

`define TBQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TBQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/tbq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbq_pkg
// shared types and constants of the touch button qualifier
// ----------------------------------------------------------------------------
package tbq_pkg;

   localparam int PADS       = 10;
   localparam int PAD_W      = 4;
   localparam int PAD_CNT_W  = PAD_W + 1;
   localparam int PAD_IDX_W  = (PADS > 1) ? $clog2(PADS) : 1;
   localparam int LEVEL_W    = 16;
   localparam int THR_W      = 8;
   localparam int PCT_W      = 8;
   localparam int PCT_SCALE  = 100;
   localparam int DIVIDEND_W = 23;
   localparam int QIDX_W     = $clog2(PCT_W);
   localparam int STEP_W     = QIDX_W + 1;
   localparam int SHIFT_W    = LEVEL_W + PCT_W;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_ACK       = 2'd1,
      OP_CALIBRATE = 2'd2,
      OP_CONFIGURE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ANS_NONE   = 2'd0,
      ANS_TAKEN  = 2'd1,
      ANS_REPEAT = 2'd2
   } ack_answer_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      op_type               operation;
      logic [PAD_W-1:0]     pad;
      logic [LEVEL_W-1:0]   level;
      logic                 enable;
      logic [THR_W-1:0]     threshold_pct;
      logic [LEVEL_W-1:0]   repeat_limit;
   } req_data_type;

   typedef struct packed {
      logic [PAD_W-1:0]     pad_out;
      logic [PCT_W-1:0]     percent;
      logic                 pressed;
      logic                 acknowledged;
      logic                 repeating;
      ack_answer_type       ack_answer;
   } rsp_data_type;

   typedef struct packed {
      logic                 enabled;
      logic [LEVEL_W-1:0]   reference;
      logic [THR_W-1:0]     threshold;
      logic [LEVEL_W-1:0]   repeat_limit;
      logic [LEVEL_W-1:0]   hold_count;
      logic [PCT_W-1:0]     percent;
      logic                 press;
      logic                 ack;
   } pad_entry_type;

   typedef struct packed {
      logic                 en;
      logic [PAD_IDX_W-1:0] idx;
      pad_entry_type        entry;
   } pad_write_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [LEVEL_W-1:0]    divisor;
   } div_cmd_type;

endpackage

// ===== rtl/core/touch_button_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// touch_button_qualifier_top
// capacitive touch pad qualifier: configure, calibrate, sample, acknowledge
// ----------------------------------------------------------------------------
// usage:
//   each req_ transaction carries one operation on one pad; every transaction
//   gives exactly one rsp_ transaction with the pad's flags after the update.
//   a transaction is taken when valid is high and stall is low.
//   a sample of an enabled pad with a nonzero reference goes through the
//   load, divide and update steps; the bit-serial divider does one trial
//   subtraction per cycle, a saturation check then 8 quotient bits, and
//   ends early when the percent saturates at 255. all other operations go
//   from the load step straight to the update step. req_stall stays high
//   from acceptance until the result is written to the output register, so
//   one transaction is in flight at a time; the next is taken the cycle after.
//   the output register holds the result while rsp_stall is high; the next
//   request is still accepted and waits in its update step until the
//   output register frees up.
//   reset clears all pad settings, references, counts and flags to zero and
//   drops rsp_valid.
// ----------------------------------------------------------------------------
`include "touch_button_qualifier_top_macros.svh"

module touch_button_qualifier_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tbq_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tbq_pkg::rsp_data_type rsp_data
);
   import tbq_pkg::*;

   state_type      state_ff, state_in;
   req_data_type   req_ff, req_in;
   logic [PCT_W-1:0] pct_ff, pct_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_data_type   rsp_data_ff, rsp_data_in;

   logic [PAD_IDX_W-1:0] pad_idx;
   pad_entry_type  cur;
   pad_entry_type  nxt;
   pad_write_type  pad_write;
   div_cmd_type    div_cmd;
   logic           div_done;
   logic [PCT_W-1:0] div_quotient;
   logic           in_range;
   logic           slot_free;
   ack_answer_type answer;

   assign pad_idx   = req_ff.pad[PAD_IDX_W-1:0];
   assign in_range  = {1'b0, req_ff.pad} < PAD_CNT_W'(PADS);
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   tbq_pad_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (pad_idx),
      .rd_entry  (cur),
      .pad_write (pad_write)
   );

   tbq_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_cmd      (div_cmd),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // pad update for the registered transaction
   always_comb begin
      nxt    = cur;
      answer = ANS_NONE;
      unique case (req_ff.operation)
         OP_SAMPLE: begin
            if (cur.enabled) begin
               nxt.percent = pct_ff;
               if (pct_ff < cur.threshold) begin
                  nxt.press = ~cur.ack;
                  if (cur.hold_count != '1) begin
                     nxt.hold_count = cur.hold_count + LEVEL_W'(1);
                  end
               end else begin
                  if (cur.ack) begin
                     nxt.press = 1'b0;
                  end
                  nxt.hold_count = '0;
                  nxt.ack        = 1'b0;
               end
            end
         end
         OP_ACK: begin
            if (cur.press) begin
               nxt.ack = 1'b1;
               answer  = ANS_TAKEN;
            end else if (cur.ack && (cur.repeat_limit != '0)
                         && (cur.hold_count > cur.repeat_limit)) begin
               answer = ANS_REPEAT;
            end
         end
         OP_CALIBRATE: begin
            if (cur.enabled) begin
               nxt.reference = req_ff.level;
            end
         end
         OP_CONFIGURE: begin
            nxt.enabled      = req_ff.enable;
            nxt.threshold    = req_ff.enable ? req_ff.threshold_pct : '0;
            nxt.repeat_limit = req_ff.enable ? req_ff.repeat_limit : '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = DIVIDEND_W'(req_ff.level) * DIVIDEND_W'(PCT_SCALE);
      div_cmd.divisor  = cur.reference;

      pad_write.en    = 1'b0;
      pad_write.idx   = pad_idx;
      pad_write.entry = nxt;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            pct_in = '0;
            if (in_range && (req_ff.operation == OP_SAMPLE) && cur.enabled
                && (cur.reference != '0)) begin
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pct_in   = div_quotient;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in         = '0;
               rsp_data_in.pad_out = req_ff.pad;
               if (in_range) begin
                  pad_write.en             = 1'b1;
                  rsp_data_in.percent      = nxt.percent;
                  rsp_data_in.pressed      = nxt.press;
                  rsp_data_in.acknowledged = nxt.ack;
                  rsp_data_in.repeating    = (nxt.repeat_limit != '0)
                                             && (nxt.hold_count > nxt.repeat_limit);
                  rsp_data_in.ack_answer   = answer;
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pct_ff      <= pct_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TBQ_ASSERT_NEXT(a_accept_loads, clock, reset, req_valid && !req_stall, state_ff == ST_LOAD)
   `TBQ_ASSERT_IMPLIES(a_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `TBQ_ASSERT_IMPLIES(a_write_in_update, clock, reset, pad_write.en, state_ff == ST_UPDATE && in_range)
   `TBQ_ASSERT_NEXT(a_update_sets_valid, clock, reset, state_ff == ST_UPDATE && slot_free, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// ===== rtl/core/tbq_divider.sv =====
// ----------------------------------------------------------------------------
// tbq_divider
// bit-serial restoring divider with saturation at the top quotient value
// ----------------------------------------------------------------------------
module tbq_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  tbq_pkg::div_cmd_type        div_cmd,
   output logic                        div_done,
   output logic [tbq_pkg::PCT_W-1:0]   div_quotient
);
   import tbq_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0]    divisor_ff, divisor_in;
   logic [PCT_W-1:0]      quot_ff, quot_in;
   logic [SHIFT_W-1:0]    shifted;
   logic [SHIFT_W:0]      trial;
   logic                  fits;

   // one trial subtraction per cycle, first step checks for saturation
   always_comb begin
      shifted = SHIFT_W'(divisor_ff) << step_ff;
      trial   = {1'b0, SHIFT_W'(rem_ff)} - {1'b0, shifted};
      fits    = ~trial[SHIFT_W];

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;

      if (div_cmd.start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(PCT_W);
         rem_in     = div_cmd.dividend;
         divisor_in = div_cmd.divisor;
         quot_in    = '0;
      end else if (busy_ff) begin
         if (step_ff == STEP_W'(PCT_W)) begin
            if (fits) begin
               quot_in = '1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end else begin
            if (fits) begin
               rem_in  = trial[DIVIDEND_W-1:0];
               quot_in = quot_ff | (PCT_W'(1) << step_ff[QIDX_W-1:0]);
            end
            if (step_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quot_ff;

endmodule

// ===== rtl/core/tbq_pad_store.sv =====
// ----------------------------------------------------------------------------
// tbq_pad_store
// per-pad settings and qualifier state, one read and one write port
// ----------------------------------------------------------------------------
module tbq_pad_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tbq_pkg::PAD_IDX_W-1:0]   rd_idx,
   output tbq_pkg::pad_entry_type          rd_entry,
   input  tbq_pkg::pad_write_type          pad_write
);
   import tbq_pkg::*;

   pad_entry_type entries_ff [PADS];
   pad_entry_type entries_in [PADS];

   always_comb begin
      for (int i = 0; i < PADS; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (pad_write.en) begin
         entries_in[pad_write.idx] = pad_write.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PADS; i++) begin
            entries_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < PADS; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   assign rd_entry = entries_ff[rd_idx];

endmodule
